// File: src/clipped_draw_window_generator_unit_assert.svh
// Assertion macros shared by the clipped draw window generator.
`ifndef CLIPPED_DRAW_WINDOW_GENERATOR_UNIT_ASSERT_SVH
`define CLIPPED_DRAW_WINDOW_GENERATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDWG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDWG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cdwg_pkg.sv
// Types, constants and helper functions of the clipped draw window generator.
package cdwg_pkg;

  localparam int COORD_BITS = 16;
  localparam int CW         = COORD_BITS + 2;
  localparam int RW         = 11;
  localparam int BW         = 10;
  localparam int PW         = 22;
  localparam int LIM_W      = 2 * RW + 1;
  localparam int NUM_BOX    = 4;
  localparam int Q_DEPTH    = 2;

  localparam logic [RW-1:0] CLIP_X_MIN_RST    = RW'(0);
  localparam logic [RW-1:0] CLIP_X_MAX_RST    = RW'(240);
  localparam logic [RW-1:0] CLIP_Y_MIN_RST    = RW'(0);
  localparam logic [RW-1:0] CLIP_Y_MAX_RST    = RW'(320);
  localparam logic [RW-1:0] SCREEN_WIDTH_RST  = RW'(240);
  localparam logic [RW-1:0] SCREEN_HEIGHT_RST = RW'(320);
  localparam logic [LIM_W-1:0] LIM_RST        = LIM_W'(2 * 240 * 320);

  localparam logic [15:0] RED_MASK   = 16'b11111;
  localparam logic [15:0] GREEN_MASK = 16'b11111100000;
  localparam logic [15:0] BLUE_MASK  = 16'b1111100000000000;

  typedef enum logic [2:0] {
    OP_PIXEL16 = 3'd0,
    OP_PIXEL24 = 3'd1,
    OP_FILL    = 3'd2,
    OP_OUTLINE = 3'd3,
    OP_HLINE   = 3'd4,
    OP_VLINE   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    REG_CLIP_X_MIN    = 3'd0,
    REG_CLIP_X_MAX    = 3'd1,
    REG_CLIP_Y_MIN    = 3'd2,
    REG_CLIP_Y_MAX    = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]                    operation;
    logic signed [COORD_BITS-1:0]  x_coord;
    logic signed [COORD_BITS-1:0]  y_coord;
    logic signed [COORD_BITS-1:0]  extent_a;
    logic signed [COORD_BITS-1:0]  extent_b;
    logic [7:0]                    line_width;
    logic [23:0]                   color_in;
  } cmd_t;

  typedef struct packed {
    logic [BW-1:0] window_x_start;
    logic [BW-1:0] window_x_end;
    logic [BW-1:0] window_y_start;
    logic [BW-1:0] window_y_end;
    logic [PW-1:0] pixel_count;
    logic [15:0]   color_out;
    logic          last_window;
  } win_t;

  // Drawable region: start inclusive, end exclusive.
  typedef struct packed {
    logic [RW-1:0] x0;
    logic [RW-1:0] x1;
    logic [RW-1:0] y0;
    logic [RW-1:0] y1;
  } region_t;

  // One clipped, non-empty window waiting for the back end; ends are exclusive.
  typedef struct packed {
    logic [RW-1:0] xs;
    logic [RW-1:0] xe;
    logic [RW-1:0] ys;
    logic [RW-1:0] ye;
    logic [15:0]   color;
    logic          last;
  } job_t;

  function automatic logic signed [CW-1:0] sext(input logic [COORD_BITS-1:0] v);
    return $signed({{(CW - COORD_BITS){v[COORD_BITS-1]}}, v});
  endfunction

  // Packs an 8-8-8 colour into the panel's RGB565 layout with red in the low bits.
  function automatic logic [15:0] rgb888_to_565(input logic [23:0] c);
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    r = 16'(c[23:16]);
    g = 16'(c[15:8]);
    b = 16'(c[7:0]);
    return ((r >> 3) & RED_MASK) | ((g << 3) & GREEN_MASK) | ((b << 8) & BLUE_MASK);
  endfunction

endpackage

// File: src/cdwg_front.sv
// Front end: builds and clips command boxes; issues one window a cycle unless stalled.
module cdwg_front import cdwg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  cmd_t    in_data_i,
  input  region_t region_i,
  output logic    job_valid_o,
  input  logic    job_ready_i,
  output job_t    job_o
);

  typedef struct packed {
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] y1;
  } box_t;

  box_t                 box_d [NUM_BOX];
  box_t                 box_q [NUM_BOX];
  job_t                 clip_job [NUM_BOX];
  logic [NUM_BOX-1:0]   raw_mask, pend_d, pend_q, nonempty, eff, sel, rest;
  logic [15:0]          color_d, color_q;
  logic signed [CW-1:0] x, y, ea, eb, xe, ye, lw, half, tail;
  logic signed [CW-1:0] rx0, rx1, ry0, ry1;
  logic signed [CW-1:0] cxs [NUM_BOX];
  logic signed [CW-1:0] cxe [NUM_BOX];
  logic signed [CW-1:0] cys [NUM_BOX];
  logic signed [CW-1:0] cye [NUM_BOX];
  logic                 ea_pos, eb_pos, lw_pos, accept, push;

  // Box generation from the incoming command.
  always_comb begin
    x      = sext(in_data_i.x_coord);
    y      = sext(in_data_i.y_coord);
    ea     = sext(in_data_i.extent_a);
    eb     = sext(in_data_i.extent_b);
    xe     = x + ea;
    ye     = y + eb;
    lw     = $signed(CW'(in_data_i.line_width));
    half   = $signed(CW'(in_data_i.line_width[7:1]));
    tail   = lw - half;
    ea_pos = !ea[CW-1] && (ea != '0);
    eb_pos = !eb[CW-1] && (eb != '0);
    lw_pos = (in_data_i.line_width != '0);
    color_d  = in_data_i.color_in[15:0];
    raw_mask = '0;
    for (int i = 0; i < NUM_BOX; i++) begin
      box_d[i] = '{x0: x, x1: x + CW'(1), y0: y, y1: y + CW'(1)};
    end
    unique case (op_e'(in_data_i.operation))
      OP_PIXEL16: begin
        raw_mask = NUM_BOX'(1);
      end
      OP_PIXEL24: begin
        raw_mask = NUM_BOX'(1);
        color_d  = rgb888_to_565(in_data_i.color_in);
      end
      OP_FILL: begin
        box_d[0] = '{x0: x, x1: xe, y0: y, y1: ye};
        raw_mask = NUM_BOX'(ea_pos && eb_pos);
      end
      OP_OUTLINE: begin
        // Top, bottom, left and right edges, in that order.
        box_d[0] = '{x0: x, x1: xe, y0: y, y1: y + CW'(1)};
        box_d[1] = '{x0: x, x1: xe, y0: ye - CW'(1), y1: ye};
        box_d[2] = '{x0: x, x1: x + CW'(1), y0: y, y1: ye};
        box_d[3] = '{x0: xe - CW'(1), x1: xe, y0: y, y1: ye};
        raw_mask = {NUM_BOX{ea_pos && eb_pos}};
      end
      OP_HLINE: begin
        box_d[0] = '{x0: x, x1: xe, y0: y - half, y1: y + tail};
        raw_mask = NUM_BOX'(ea_pos && lw_pos);
      end
      OP_VLINE: begin
        box_d[0] = '{x0: x - half, x1: x + tail, y0: y, y1: y + ea};
        raw_mask = NUM_BOX'(ea_pos && lw_pos);
      end
      default: begin
        raw_mask = '0;
      end
    endcase
  end

  // Clipping of the held boxes against the drawable region.
  always_comb begin
    rx0 = $signed(CW'(region_i.x0));
    rx1 = $signed(CW'(region_i.x1));
    ry0 = $signed(CW'(region_i.y0));
    ry1 = $signed(CW'(region_i.y1));
    for (int i = 0; i < NUM_BOX; i++) begin
      cxs[i] = (box_q[i].x0 > rx0) ? box_q[i].x0 : rx0;
      cxe[i] = (box_q[i].x1 < rx1) ? box_q[i].x1 : rx1;
      cys[i] = (box_q[i].y0 > ry0) ? box_q[i].y0 : ry0;
      cye[i] = (box_q[i].y1 < ry1) ? box_q[i].y1 : ry1;
      nonempty[i] = (cxs[i] < cxe[i]) && (cys[i] < cye[i]);
      clip_job[i] = '{xs: cxs[i][RW-1:0], xe: cxe[i][RW-1:0],
                      ys: cys[i][RW-1:0], ye: cye[i][RW-1:0],
                      color: color_q, last: 1'b0};
    end
  end

  // The lowest pending non-empty box goes out next.
  always_comb begin
    eff  = pend_q & nonempty;
    sel  = eff & (~eff + NUM_BOX'(1));
    rest = eff & ~sel;
    job_o = '0;
    for (int i = 0; i < NUM_BOX; i++) begin
      if (sel[i]) begin
        job_o = clip_job[i];
      end
    end
    job_o.last  = (rest == '0);
    job_valid_o = (eff != '0);
    push        = job_valid_o && job_ready_i;
    in_ready_o  = !job_valid_o || (job_ready_i && (rest == '0));
    accept      = in_valid_i && in_ready_o;
    pend_d      = pend_q;
    if (push) begin
      pend_d = rest;
    end else if (eff == '0) begin
      pend_d = '0;
    end
    if (accept) begin
      pend_d = raw_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      box_q   <= box_d;
      color_q <= color_d;
    end
  end

endmodule

// File: src/cdwg_queue.sv
// Short window queue between the front end and the back end.
module cdwg_queue import cdwg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_data_o
);

  localparam int PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CntW = $clog2(Q_DEPTH + 1);

  job_t            mem_q [Q_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  always_comb begin
    push_ready_o = (count_q != CntW'(Q_DEPTH));
    pop_valid_o  = (count_q != '0);
    pop_data_o   = mem_q[rd_ptr_q];
    do_push      = push_valid_i && push_ready_o;
    do_pop       = pop_valid_o && pop_ready_i;
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    count_d      = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: src/cdwg_back.sv
// Back end: turns a clipped window into inclusive bounds and a checked pixel count.
module cdwg_back import cdwg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  job_t             job_i,
  input  logic [LIM_W-1:0] lim_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output win_t             out_data_o
);

  typedef struct packed {
    logic [BW-1:0] xs;
    logic [BW-1:0] xl;
    logic [BW-1:0] ys;
    logic [BW-1:0] yl;
    logic [RW-1:0] dx;
    logic [RW-1:0] dy;
    logic [15:0]   color;
    logic          last;
  } stage_t;

  stage_t          a_d, a_q;
  win_t            win_d, win_q;
  logic            a_valid_q, out_valid_q, out_free;
  logic [RW-1:0]   xl, yl;
  logic [2*RW-1:0] cnt;
  logic            over;

  always_comb begin
    xl   = job_i.xe - RW'(1);
    yl   = job_i.ye - RW'(1);
    a_d  = '{xs: job_i.xs[BW-1:0], xl: xl[BW-1:0],
             ys: job_i.ys[BW-1:0], yl: yl[BW-1:0],
             dx: job_i.xe - job_i.xs, dy: job_i.ye - job_i.ys,
             color: job_i.color, last: job_i.last};
    cnt  = (2 * RW)'(a_q.dx) * (2 * RW)'(a_q.dy);
    over = LIM_W'(cnt) > lim_i;
    win_d = '{window_x_start: a_q.xs, window_x_end: a_q.xl,
              window_y_start: a_q.ys, window_y_end: a_q.yl,
              pixel_count: over ? '0 : PW'(cnt),
              color_out: a_q.color, last_window: a_q.last};
    out_free    = !out_valid_q || out_ready_i;
    job_ready_o = !a_valid_q || out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_ready_o) begin
        a_valid_q <= job_valid_i;
      end
      if (out_free) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      a_q <= a_d;
    end
    if (out_free && a_valid_q) begin
      win_q <= win_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = win_q;

endmodule

// File: src/clipped_draw_window_generator_unit.sv
// Top level of the clipped draw window generator: configuration, region and wiring.
`include "clipped_draw_window_generator_unit_assert.svh"

// Each drawing command transaction on the input channel turns into zero to four window
// transactions on the output channel, in order, the final one flagged by last_window.
// The front end holds one command, clips all of its boxes against the drawable region
// (the clip registers intersected with the screen size and MAX_SCREEN_DIM) in parallel,
// and hands one non-empty window per cycle to a two-entry queue while it has room; the
// back end computes the inclusive bounds, then the pixel count and its limit check, over
// two registered stages. A command therefore occupies the front end until its last
// surviving window is handed on: pixels, filled rectangles and lines yield at most one
// window, an outlined rectangle up to four. A new command is taken in the cycle its
// predecessor's last window moves into the queue, so windows, and commands of at most
// one window, stream at one per cycle when the output is not stalled.
// Configuration writes are always accepted and must only be made while no command is
// in flight; register indexes beyond the list are ignored.
module clipped_draw_window_generator_unit import cdwg_pkg::*; #(
  parameter int MAX_SCREEN_DIM = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cmd_t          in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output win_t          out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [RW-1:0] cfg_data_i
);

  // The dimension cap is compared at whatever width holds both it and a register.
  localparam int DimW = $clog2(MAX_SCREEN_DIM + 1);
  localparam int MW   = (DimW > RW) ? DimW : RW;
  localparam logic [MW-1:0] MaxDim = MW'(MAX_SCREEN_DIM);

  logic [RW-1:0]    clip_x_min_q, clip_x_max_q, clip_y_min_q, clip_y_max_q;
  logic [RW-1:0]    screen_width_q, screen_height_q;
  logic [LIM_W-1:0] lim_q, lim_d;
  logic [MW-1:0]    x_lim, y_lim;
  region_t          region;
  logic             job_valid, job_ready, q_valid, q_ready;
  job_t             job, q_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_x_min_q    <= CLIP_X_MIN_RST;
      clip_x_max_q    <= CLIP_X_MAX_RST;
      clip_y_min_q    <= CLIP_Y_MIN_RST;
      clip_y_max_q    <= CLIP_Y_MAX_RST;
      screen_width_q  <= SCREEN_WIDTH_RST;
      screen_height_q <= SCREEN_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CLIP_X_MIN:    clip_x_min_q    <= cfg_data_i;
        REG_CLIP_X_MAX:    clip_x_max_q    <= cfg_data_i;
        REG_CLIP_Y_MIN:    clip_y_min_q    <= cfg_data_i;
        REG_CLIP_Y_MAX:    clip_y_max_q    <= cfg_data_i;
        REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        REG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The pixel count limit is twice the screen area. It is registered here, since a
  // command passes through the front end and the queue before it reaches the back end.
  assign lim_d = {(2 * RW)'(screen_width_q) * (2 * RW)'(screen_height_q), 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LIM_RST;
    end else begin
      lim_q <= lim_d;
    end
  end

  // The drawable end bound is the smallest of the clip end, the screen size and the cap.
  always_comb begin
    x_lim = MW'(clip_x_max_q);
    if (MW'(screen_width_q) < x_lim) begin
      x_lim = MW'(screen_width_q);
    end
    if (MaxDim < x_lim) begin
      x_lim = MaxDim;
    end
    y_lim = MW'(clip_y_max_q);
    if (MW'(screen_height_q) < y_lim) begin
      y_lim = MW'(screen_height_q);
    end
    if (MaxDim < y_lim) begin
      y_lim = MaxDim;
    end
    region = '{x0: clip_x_min_q, x1: x_lim[RW-1:0], y0: clip_y_min_q, y1: y_lim[RW-1:0]};
  end

  cdwg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .region_i    (region),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  cdwg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_job)
  );

  cdwg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .lim_i       (lim_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Only non-empty windows enter the queue.
  `CDWG_ASSERT_SAME(a_job_not_empty, job_valid && job_ready, (job.xs < job.xe) && (job.ys < job.ye), "empty window entered the queue")

  // A new command is only taken while the previous command's final window leaves.
  `CDWG_ASSERT_SAME(a_cmd_after_last, in_valid_i && in_ready_o && job_valid, job_ready && job.last, "command taken over a pending window")

  // An unknown operation leaves nothing behind in the front end.
  `CDWG_ASSERT_NEXT(a_unknown_op_drop, in_valid_i && in_ready_o && (in_data_i.operation > 3'(OP_VLINE)), !job_valid, "unknown operation produced a window")

endmodule
